// ===== src/gda_pkg.sv =====
package gda_pkg;

  localparam int DAY_W     = 5;
  localparam int MON_W     = 4;
  localparam int YEAR_W    = 14;
  localparam int ADV_W     = 16;
  localparam int SER_W     = 23;  // serial plus count for any year up to 16383
  localparam int OUT_SER_W = 22;
  localparam int CUM_W     = 9;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int MAX_YEAR_DEF    = 9999;

  localparam int FB_DAY   = 1;
  localparam int FB_MONTH = 1;
  localparam int FB_YEAR  = 2026;

  // y / 100 == (y * RECIP100) >> RECIP_SH for all 14-bit y
  localparam int RECIP100 = 5243;
  localparam int RECIP_SH = 19;
  localparam int K_W      = 13;
  localparam int PROD_W   = YEAR_W + K_W;
  localparam int Q100_W   = 8;

  localparam int DAYS_400 = 146097;
  localparam int DAYS_100 = 36524;
  localparam int DAYS_4   = 1461;
  localparam int DAYS_1   = 365;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
  } date_t;

  typedef struct packed {
    logic                 first_valid;
    logic                 second_valid;
    logic [DAY_W-1:0]     next_day;
    logic [MON_W-1:0]     next_month;
    logic [YEAR_W-1:0]    next_year;
    logic                 overflow;
    logic [OUT_SER_W-1:0] serial_number;
    logic [OUT_SER_W-1:0] distance;
    logic                 is_earlier;
    logic                 is_equal;
  } result_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LMUL,
    ST_CHECK,
    ST_PMUL,
    ST_M365,
    ST_S0,
    ST_S1,
    ST_S2,
    ST_S3,
    ST_S4,
    ST_D1,
    ST_D2,
    ST_TGT,
    ST_OVF,
    ST_N,
    ST_Q400,
    ST_Q100,
    ST_Q4,
    ST_Q1,
    ST_MON,
    ST_DONE
  } state_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // days in the year before the first of month m
  function automatic logic [CUM_W-1:0] cum_days(input logic [MON_W-1:0] m, input logic leap);
    logic [CUM_W-1:0] c;
    case (m)
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    if (leap && m > 4'd2) begin
      c = c + 9'd1;
    end
    return c;
  endfunction

endpackage

// ===== src/gda_alu.sv =====
module gda_alu #(
  parameter int W = gda_pkg::SER_W
) (
  input  gda_pkg::alu_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [W-1:0]     res,
  output logic             borrow
);

  logic [W:0] sum;

  always_comb begin
    if (op == gda_pkg::ALU_SUB) begin
      sum = {1'b0, a} - {1'b0, b};
    end else begin
      sum = {1'b0, a} + {1'b0, b};
    end
  end

  assign res    = sum[W-1:0];
  assign borrow = (op == gda_pkg::ALU_SUB) && sum[W];

endmodule

// ===== src/gda_core.sv =====
module gda_core #(
  parameter int MAX_YEAR = gda_pkg::MAX_YEAR_DEF,
  parameter int CNT_W    = gda_pkg::COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  gda_pkg::date_t       first_in,
  input  gda_pkg::date_t       second_in,
  input  logic [CNT_W-1:0]     cnt_in,
  output logic                 idle,
  output logic                 done,
  input  logic                 take,
  output gda_pkg::result_t     result
);

  localparam int SW = gda_pkg::SER_W;
  localparam int YW = gda_pkg::YEAR_W;
  localparam int PW = gda_pkg::PROD_W;
  localparam int QW = gda_pkg::Q100_W;

  // serial of 31/12/MAX_YEAR
  localparam logic [SW-1:0] LIMIT =
    SW'(365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400);
  localparam logic [YW-1:0] MAX_Y = YW'(MAX_YEAR);

  gda_pkg::state_t state, state_next;

  gda_pkg::date_t da, db, cur;
  logic [CNT_W-1:0] cnt;
  logic             sel;
  logic             leap;
  logic             v_a, v_b;
  logic [PW-1:0]    prod;
  logic [QW-1:0]    q;
  logic [SW-1:0]    acc, s_a, span;
  logic             earlier, equal, ovf;
  logic [YW-1:0]    yacc;
  logic [gda_pkg::MON_W-1:0] mcur;
  logic [gda_pkg::DAY_W-1:0] nd;
  logic [4:0]       k;
  logic             c100_3, q4_24, leap_n;

  gda_pkg::alu_op_t alu_op;
  logic [SW-1:0]    alu_a, alu_b, alu_res;
  logic             alu_borrow;

  logic [YW-1:0]    p;
  logic [YW-1:0]    mul_a;
  logic [gda_pkg::K_W-1:0] mul_k;
  logic [PW-1:0]    mul_res;
  logic [QW-1:0]    q100_c;
  logic [YW-1:0]    hund;
  logic             leap_c, valid_c;
  logic [YW-1:0]    ystep;
  logic [gda_pkg::DAY_W-1:0] mlen;

  gda_alu #(.W(SW)) u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  assign cur  = sel ? db : da;
  assign p    = cur.year - YW'(1);
  assign mlen = gda_pkg::month_len(mcur, leap_n);

  // leap test and validity of the current raw date
  assign q100_c = prod[gda_pkg::RECIP_SH +: QW];
  assign hund   = YW'({q100_c, 6'b0}) + YW'({q100_c, 5'b0}) + YW'({q100_c, 2'b0});
  assign leap_c = (cur.year[1:0] == 2'b00) && ((cur.year != hund) || (q100_c[1:0] == 2'b00));
  assign valid_c = (cur.year != '0) && (cur.year <= MAX_Y) &&
                   (cur.month != '0) && (cur.month <= 4'd12) &&
                   (cur.day != '0) &&
                   (cur.day <= gda_pkg::month_len(cur.month, leap_c));

  always_comb begin
    mul_a = (state == gda_pkg::ST_LMUL) ? cur.year : p;
    mul_k = (state == gda_pkg::ST_M365) ? gda_pkg::K_W'(gda_pkg::DAYS_1)
                                        : gda_pkg::K_W'(gda_pkg::RECIP100);
  end

  assign mul_res = PW'(mul_a) * PW'(mul_k);

  always_comb begin
    state_next = state;
    alu_op     = gda_pkg::ALU_ADD;
    alu_a      = acc;
    alu_b      = '0;
    ystep      = '0;
    case (state)
      gda_pkg::ST_IDLE:  if (start) state_next = gda_pkg::ST_LMUL;
      gda_pkg::ST_LMUL:  state_next = gda_pkg::ST_CHECK;
      gda_pkg::ST_CHECK: state_next = gda_pkg::ST_PMUL;
      gda_pkg::ST_PMUL:  state_next = gda_pkg::ST_M365;
      gda_pkg::ST_M365:  state_next = gda_pkg::ST_S0;
      gda_pkg::ST_S0: begin
        alu_a      = prod[SW-1:0];
        state_next = gda_pkg::ST_S1;
      end
      gda_pkg::ST_S1: begin
        alu_b      = SW'(p[YW-1:2]);
        state_next = gda_pkg::ST_S2;
      end
      gda_pkg::ST_S2: begin
        alu_op     = gda_pkg::ALU_SUB;
        alu_b      = SW'(q);
        state_next = gda_pkg::ST_S3;
      end
      gda_pkg::ST_S3: begin
        alu_b      = SW'(q[QW-1:2]);
        state_next = gda_pkg::ST_S4;
      end
      gda_pkg::ST_S4: begin
        alu_b      = SW'(10'(gda_pkg::cum_days(cur.month, leap)) + 10'(cur.day));
        state_next = sel ? gda_pkg::ST_D1 : gda_pkg::ST_LMUL;
      end
      gda_pkg::ST_D1: begin
        alu_op     = gda_pkg::ALU_SUB;
        alu_a      = s_a;
        alu_b      = acc;
        state_next = alu_borrow ? gda_pkg::ST_D2 : gda_pkg::ST_TGT;
      end
      gda_pkg::ST_D2: begin
        alu_op     = gda_pkg::ALU_SUB;
        alu_b      = s_a;
        state_next = gda_pkg::ST_TGT;
      end
      gda_pkg::ST_TGT: begin
        alu_a      = s_a;
        alu_b      = SW'(cnt);
        state_next = gda_pkg::ST_OVF;
      end
      gda_pkg::ST_OVF: begin
        alu_op     = gda_pkg::ALU_SUB;
        alu_a      = LIMIT;
        alu_b      = acc;
        state_next = alu_borrow ? gda_pkg::ST_DONE : gda_pkg::ST_N;
      end
      gda_pkg::ST_N: begin
        alu_op     = gda_pkg::ALU_SUB;
        alu_b      = SW'(1);
        state_next = gda_pkg::ST_Q400;
      end
      gda_pkg::ST_Q400: begin
        alu_op = gda_pkg::ALU_SUB;
        alu_b  = SW'(gda_pkg::DAYS_400);
        ystep  = YW'(400);
        if (alu_borrow) state_next = gda_pkg::ST_Q100;
      end
      gda_pkg::ST_Q100: begin
        alu_op = gda_pkg::ALU_SUB;
        alu_b  = SW'(gda_pkg::DAYS_100);
        ystep  = YW'(100);
        if (alu_borrow || k == 5'd3) state_next = gda_pkg::ST_Q4;
      end
      gda_pkg::ST_Q4: begin
        alu_op = gda_pkg::ALU_SUB;
        alu_b  = SW'(gda_pkg::DAYS_4);
        ystep  = YW'(4);
        if (alu_borrow) state_next = gda_pkg::ST_Q1;
      end
      gda_pkg::ST_Q1: begin
        alu_op = gda_pkg::ALU_SUB;
        alu_b  = SW'(gda_pkg::DAYS_1);
        ystep  = YW'(1);
        if (alu_borrow || k == 5'd3) state_next = gda_pkg::ST_MON;
      end
      gda_pkg::ST_MON: begin
        alu_op = gda_pkg::ALU_SUB;
        alu_b  = SW'(mlen);
        if (alu_borrow || mcur == 4'd12) state_next = gda_pkg::ST_DONE;
      end
      gda_pkg::ST_DONE:  if (take) state_next = gda_pkg::ST_IDLE;
      default:           state_next = gda_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gda_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      gda_pkg::ST_IDLE: begin
        if (start) begin
          da  <= first_in;
          db  <= second_in;
          cnt <= cnt_in;
          sel <= 1'b0;
        end
      end
      gda_pkg::ST_LMUL: prod <= mul_res;
      gda_pkg::ST_CHECK: begin
        leap <= valid_c && leap_c;
        if (sel) begin
          v_b <= valid_c;
        end else begin
          v_a <= valid_c;
        end
        if (!valid_c) begin
          if (sel) begin
            db <= '{gda_pkg::DAY_W'(gda_pkg::FB_DAY), gda_pkg::MON_W'(gda_pkg::FB_MONTH),
                    YW'(gda_pkg::FB_YEAR)};
          end else begin
            da <= '{gda_pkg::DAY_W'(gda_pkg::FB_DAY), gda_pkg::MON_W'(gda_pkg::FB_MONTH),
                    YW'(gda_pkg::FB_YEAR)};
          end
        end
      end
      gda_pkg::ST_PMUL: prod <= mul_res;
      gda_pkg::ST_M365: begin
        q    <= q100_c;
        prod <= mul_res;
      end
      gda_pkg::ST_S0, gda_pkg::ST_S1, gda_pkg::ST_S2, gda_pkg::ST_S3: acc <= alu_res;
      gda_pkg::ST_S4: begin
        acc <= alu_res;
        if (!sel) begin
          s_a <= alu_res;
          sel <= 1'b1;
        end
      end
      gda_pkg::ST_D1: begin
        earlier <= alu_borrow;
        equal   <= (alu_res == '0);
        span    <= alu_res;
      end
      gda_pkg::ST_D2: span <= alu_res;
      gda_pkg::ST_TGT: acc <= alu_res;
      gda_pkg::ST_OVF: begin
        ovf <= alu_borrow;
        if (alu_borrow) begin
          nd   <= gda_pkg::DAY_W'(31);
          mcur <= 4'd12;
          yacc <= MAX_Y;
        end
      end
      gda_pkg::ST_N: begin
        acc  <= alu_res;
        yacc <= YW'(1);
        k    <= '0;
      end
      gda_pkg::ST_Q400: begin
        if (!alu_borrow) begin
          acc  <= alu_res;
          yacc <= yacc + ystep;
        end
      end
      gda_pkg::ST_Q100: begin
        if (!alu_borrow && k != 5'd3) begin
          acc  <= alu_res;
          yacc <= yacc + ystep;
          k    <= k + 5'd1;
        end else begin
          c100_3 <= (k == 5'd3);
          k      <= '0;
        end
      end
      gda_pkg::ST_Q4: begin
        if (!alu_borrow) begin
          acc  <= alu_res;
          yacc <= yacc + ystep;
          k    <= k + 5'd1;
        end else begin
          q4_24 <= (k == 5'd24);
          k     <= '0;
        end
      end
      gda_pkg::ST_Q1: begin
        if (!alu_borrow && k != 5'd3) begin
          acc  <= alu_res;
          yacc <= yacc + ystep;
          k    <= k + 5'd1;
        end else begin
          // last year of a 4-year group is leap, unless it ends a plain century
          leap_n <= (k == 5'd3) && (!q4_24 || c100_3);
          mcur   <= 4'd1;
        end
      end
      gda_pkg::ST_MON: begin
        if (!alu_borrow && mcur != 4'd12) begin
          acc  <= alu_res;
          mcur <= mcur + 4'd1;
        end else begin
          nd <= acc[gda_pkg::DAY_W-1:0] + gda_pkg::DAY_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign idle = (state == gda_pkg::ST_IDLE);
  assign done = (state == gda_pkg::ST_DONE);

  assign result.first_valid   = v_a;
  assign result.second_valid  = v_b;
  assign result.next_day      = nd;
  assign result.next_month    = mcur;
  assign result.next_year     = yacc;
  assign result.overflow      = ovf;
  assign result.serial_number = s_a[gda_pkg::OUT_SER_W-1:0];
  assign result.distance      = span[gda_pkg::OUT_SER_W-1:0];
  assign result.is_earlier    = earlier;
  assign result.is_equal      = equal;

endmodule

// ===== src/gregorian_date_arithmetic_unit.sv =====
// The date breakdown peels 400-year blocks one per cycle through the shared adder.
// Items are handled one at a time; the next item is taken the cycle after the
// sequencer hands its result to the output register, and a result still waiting
// there holds the sequencer and so the input.
// Reset (synchronous, active high) returns the sequencer to idle and clears out_valid.
module gregorian_date_arithmetic_unit #(
  parameter int COUNT_WIDTH = gda_pkg::COUNT_WIDTH_DEF,
  parameter int MAX_YEAR    = gda_pkg::MAX_YEAR_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [gda_pkg::DAY_W-1:0]       day,
  input  logic [gda_pkg::MON_W-1:0]       month,
  input  logic [gda_pkg::YEAR_W-1:0]      year,
  input  logic [gda_pkg::DAY_W-1:0]       other_day,
  input  logic [gda_pkg::MON_W-1:0]       other_month,
  input  logic [gda_pkg::YEAR_W-1:0]      other_year,
  input  logic [gda_pkg::ADV_W-1:0]       advance_days,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            first_valid,
  output logic                            second_valid,
  output logic [gda_pkg::DAY_W-1:0]       next_day,
  output logic [gda_pkg::MON_W-1:0]       next_month,
  output logic [gda_pkg::YEAR_W-1:0]      next_year,
  output logic                            overflow,
  output logic [gda_pkg::OUT_SER_W-1:0]   serial_number,
  output logic [gda_pkg::OUT_SER_W-1:0]   distance,
  output logic                            is_earlier,
  output logic                            is_equal
);

  localparam int CNT_W = (COUNT_WIDTH < gda_pkg::ADV_W) ? COUNT_WIDTH : gda_pkg::ADV_W;

  gda_pkg::date_t   first_in, second_in;
  gda_pkg::result_t core_res, res;
  logic             core_idle, core_done, load;

  assign first_in  = '{day, month, year};
  assign second_in = '{other_day, other_month, other_year};

  gda_core #(
    .MAX_YEAR (MAX_YEAR),
    .CNT_W    (CNT_W)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid && in_ready),
    .first_in  (first_in),
    .second_in (second_in),
    .cnt_in    (advance_days[CNT_W-1:0]),
    .idle      (core_idle),
    .done      (core_done),
    .take      (load),
    .result    (core_res)
  );

  assign in_ready = core_idle;
  assign load     = core_done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= core_res;
    end
  end

  assign first_valid   = res.first_valid;
  assign second_valid  = res.second_valid;
  assign next_day      = res.next_day;
  assign next_month    = res.next_month;
  assign next_year     = res.next_year;
  assign overflow      = res.overflow;
  assign serial_number = res.serial_number;
  assign distance      = res.distance;
  assign is_earlier    = res.is_earlier;
  assign is_equal      = res.is_equal;

endmodule
